// ===== hdl/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the sphere map to cube texel address block.
// ----------------------------------------------------------------------------
package stc_pkg;

	// Width of the sub-pixel numerator 16*p + 8 + d for a 12-bit pixel
	localparam int NUM_W = 17;

	// Configuration register indexes
	localparam logic [1:0] CFG_OUTPUT_SIZE = 2'd0;
	localparam logic [1:0] CFG_FACE_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_FACE_HEIGHT = 2'd2;
	localparam logic [1:0] CFG_AA_FIVE     = 2'd3;

	// Cube face codes
	localparam logic [2:0] CUBE_PX = 3'd0;
	localparam logic [2:0] CUBE_NX = 3'd1;
	localparam logic [2:0] CUBE_PY = 3'd2;
	localparam logic [2:0] CUBE_NY = 3'd3;
	localparam logic [2:0] CUBE_PZ = 3'd4;
	localparam logic [2:0] CUBE_NZ = 3'd5;

	// Sample numbers
	localparam logic [2:0] SMP_FIRST     = 3'd0;
	localparam logic [2:0] SMP_LAST_FIVE = 3'd4;

	// One sample as it travels from the front end to the back end
	typedef struct packed {
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
		logic [2:0]       smp;
		logic             last;
	} stc_sample_t;

	// Sample offset pattern, in sixteenths of a pixel
	function automatic logic signed [4:0] pat_dx(input logic [2:0] k);
		logic signed [4:0] d;
		case (k)
			3'd1:    d = -5'sd3;
			3'd2:    d = 5'sd6;
			3'd3:    d = 5'sd3;
			3'd4:    d = -5'sd6;
			default: d = 5'sd0;
		endcase
		return d;
	endfunction

	function automatic logic signed [4:0] pat_dy(input logic [2:0] k);
		logic signed [4:0] d;
		case (k)
			3'd1:    d = -5'sd6;
			3'd2:    d = -5'sd3;
			3'd3:    d = 5'sd6;
			3'd4:    d = 5'sd3;
			default: d = 5'sd0;
		endcase
		return d;
	endfunction

endpackage

// ===== hdl/stc_front.sv =====
// ----------------------------------------------------------------------------
// stc_front
// Accepts pixels and expands each into one or five sample numerators.
// ----------------------------------------------------------------------------
module stc_front
	import stc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         aa_five,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [11:0]  pixel_x,
	input  logic [11:0]  pixel_y,
	input  logic         q_full,
	output logic         q_push,
	output stc_sample_t  q_data
);

	logic        busy_q;
	logic [11:0] px_q;
	logic [11:0] py_q;
	logic [2:0]  k_q;
	logic [2:0]  last_k;
	logic        push_last;
	logic        accept;

	// Sample sequencing
	assign last_k    = aa_five ? SMP_LAST_FIVE : SMP_FIRST;
	assign q_push    = busy_q && !q_full;
	assign push_last = q_push && (k_q == last_k);
	assign in_stall  = busy_q && !push_last;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= SMP_FIRST;
		end else if (accept) begin
			busy_q <= 1'b1;
			k_q    <= SMP_FIRST;
		end else if (push_last) begin
			busy_q <= 1'b0;
		end else if (q_push) begin
			k_q <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
	end

	// Numerators 16*p + 8 + offset, always positive
	always_comb begin
		q_data.num_x = {1'b0, px_q, 4'b0} + NUM_W'(8) + NUM_W'(pat_dx(k_q));
		q_data.num_y = {1'b0, py_q, 4'b0} + NUM_W'(8) + NUM_W'(pat_dy(k_q));
		q_data.smp   = k_q;
		q_data.last  = (k_q == last_k);
	end

endmodule

// ===== hdl/stc_fifo.sv =====
// ----------------------------------------------------------------------------
// stc_fifo
// Short flop-based queue between the front end and the back end.
// ----------------------------------------------------------------------------
module stc_fifo #(
	parameter int W     = 38,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== hdl/stc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// stc_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Numerators must be below twice the shared divisor.
// ----------------------------------------------------------------------------
module stc_div_pipe #(
	parameter int DW = 20,
	parameter int QW = 21,
	parameter int SW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW:0]   num_x,
	input  logic [DW:0]   num_y,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_i,
	output logic          out_vld,
	output logic [QW-1:0] quo_x,
	output logic [QW-1:0] quo_y,
	output logic [SW-1:0] side_o
);

	logic [DW:0]   rx_q   [QW];
	logic [DW:0]   ry_q   [QW];
	logic [QW-1:0] qx_q   [QW];
	logic [QW-1:0] qy_q   [QW];
	logic [DW-1:0] den_q  [QW];
	logic [SW-1:0] side_q [QW];
	logic          vld_q  [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stg
		logic [DW:0]   rx_in, ry_in, nrx, nry;
		logic [QW-1:0] qx_in, qy_in;
		logic [DW-1:0] d_in;
		logic [SW-1:0] sd_in;
		logic          v_in, gx, gy;

		// First stage takes the numerator as is, later ones shift in a zero
		if (j == 0) begin : g_first
			assign rx_in = num_x;
			assign ry_in = num_y;
			assign qx_in = '0;
			assign qy_in = '0;
			assign d_in  = den;
			assign sd_in = side_i;
			assign v_in  = in_vld;
		end else begin : g_next
			assign rx_in = {rx_q[j-1][DW-1:0], 1'b0};
			assign ry_in = {ry_q[j-1][DW-1:0], 1'b0};
			assign qx_in = qx_q[j-1];
			assign qy_in = qy_q[j-1];
			assign d_in  = den_q[j-1];
			assign sd_in = side_q[j-1];
			assign v_in  = vld_q[j-1];
		end

		// Compare and subtract
		assign gx  = (rx_in >= {1'b0, d_in});
		assign gy  = (ry_in >= {1'b0, d_in});
		assign nrx = gx ? (rx_in - {1'b0, d_in}) : rx_in;
		assign nry = gy ? (ry_in - {1'b0, d_in}) : ry_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_q[j]   <= nrx;
				ry_q[j]   <= nry;
				qx_q[j]   <= {qx_in[QW-2:0], gx};
				qy_q[j]   <= {qy_in[QW-2:0], gy};
				den_q[j]  <= d_in;
				side_q[j] <= sd_in;
			end
		end
	end

	assign out_vld = vld_q[QW-1];
	assign quo_x   = qx_q[QW-1];
	assign quo_y   = qy_q[QW-1];
	assign side_o  = side_q[QW-1];

endmodule

// ===== hdl/stc_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// stc_sqrt_pipe
// Pipelined integer square root, one root bit per stage, MSB first.
// ----------------------------------------------------------------------------
module stc_sqrt_pipe #(
	parameter int RW = 21,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [2*RW-2:0] v,
	input  logic [SW-1:0]   side_i,
	output logic            out_vld,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_o
);

	localparam int VW = 2 * RW - 1;
	localparam int TW = 2 * RW + 1;

	logic [VW-1:0] rem_q  [RW];
	logic [RW-1:0] root_q [RW];
	logic [SW-1:0] side_q [RW];
	logic          vld_q  [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stg
		localparam int K = RW - 1 - j;
		logic [VW-1:0] rem_in, rem_n;
		logic [RW-1:0] root_in, root_n;
		logic [SW-1:0] sd_in;
		logic          v_in, ge;
		logic [TW-1:0] trial;

		if (j == 0) begin : g_first
			assign rem_in  = v;
			assign root_in = '0;
			assign sd_in   = side_i;
			assign v_in    = in_vld;
		end else begin : g_next
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
			assign sd_in   = side_q[j-1];
			assign v_in    = vld_q[j-1];
		end

		// Setting bit K adds 2*root*2^K + 2^2K to the square
		assign trial  = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
		assign ge     = (TW'(rem_in) >= trial);
		assign rem_n  = ge ? (rem_in - trial[VW-1:0]) : rem_in;
		assign root_n = ge ? (root_in | (RW'(1) << K)) : root_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= rem_n;
				root_q[j] <= root_n;
				side_q[j] <= sd_in;
			end
		end
	end

	assign out_vld = vld_q[RW-1];
	assign root    = root_q[RW-1];
	assign side_o  = side_q[RW-1];

endmodule

// ===== hdl/stc_back.sv =====
// ----------------------------------------------------------------------------
// stc_back
// Sample pipeline: map coordinates, sphere inversion, face selection and
// texel address, one sample per cycle, stalled as a whole by the output.
// ----------------------------------------------------------------------------
module stc_back
	import stc_pkg::*;
#(
	parameter int F  = 20,
	parameter int NW = 13,
	parameter int WW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] n,
	input  logic [WW-1:0] w,
	input  logic [WW-1:0] h,
	input  logic          smp_valid,
	input  stc_sample_t   smp_in,
	output logic          smp_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    face,
	output logic [11:0]   texel_x,
	output logic [11:0]   texel_y,
	output logic [2:0]    sample_number,
	output logic          last
);

	localparam int QW  = F + 1;
	localparam int DW1 = NW + 4;
	localparam int CW  = (NW + 5 > NUM_W) ? NW + 5 : NUM_W;
	localparam int DW2 = F + 3;
	localparam int SW1 = 6;
	localparam int SWS = 3 * F + 10;
	localparam int SW2 = 8;
	localparam int PW  = F + 1 + WW;
	localparam logic [QW-1:0] ONE = QW'(1) << F;

	logic en;

	// -------------------------------------------------- map coordinates
	logic [DW1-1:0] d1;
	logic [CW-1:0]  numx_ext, numy_ext;
	logic           ovx, ovy;
	logic [DW1:0]   nx1, ny1;
	logic           v_d1;
	logic [QW-1:0]  s_d1, t_d1;
	logic [SW1-1:0] side_d1;

	assign en      = !out_valid || !out_stall;
	assign smp_pop = en && smp_valid;

	always_comb begin
		d1       = {n, 4'b0};
		numx_ext = CW'(smp_in.num_x);
		numy_ext = CW'(smp_in.num_y);
		ovx      = numx_ext >= CW'({d1, 1'b0});
		ovy      = numy_ext >= CW'({d1, 1'b0});
		nx1      = ovx ? '0 : numx_ext[DW1:0];
		ny1      = ovy ? '0 : numy_ext[DW1:0];
	end

	stc_div_pipe #(.DW(DW1), .QW(QW), .SW(SW1)) u_div_map (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (smp_valid),
		.num_x  (nx1),
		.num_y  (ny1),
		.den    (d1),
		.side_i ({ovx, ovy, smp_in.smp, smp_in.last}),
		.out_vld(v_d1),
		.quo_x  (s_d1),
		.quo_y  (t_d1),
		.side_o (side_d1)
	);

	// -------------------------------------------------- stage 1: a, b
	logic [F+2:0] a2x, a2y, amx, amy;
	logic         inr;
	logic         vld_s1, asgn_s1, bsgn_s1, inr_s1, last_s1;
	logic [F:0]   amag_s1, bmag_s1;
	logic [2:0]   smp_s1;

	always_comb begin
		a2x = {1'b0, s_d1, 1'b0} - (F+3)'(ONE);
		a2y = {1'b0, t_d1, 1'b0} - (F+3)'(ONE);
		amx = a2x[F+2] ? ((F+3)'(0) - a2x) : a2x;
		amy = a2y[F+2] ? ((F+3)'(0) - a2y) : a2y;
		inr = !side_d1[5] && !side_d1[4] && (s_d1 <= ONE) && (t_d1 <= ONE);
	end

	// -------------------------------------------------- stage 2: squares
	logic             vld_s2, asgn_s2, bsgn_s2, inr_s2, last_s2;
	logic [F:0]       amag_s2, bmag_s2;
	logic [2*F+1:0]   aa_s2, bb_s2;
	logic [2:0]       smp_s2;

	// -------------------------------------------------- stage 3: radicand
	logic [2*F+2:0] sum3;
	logic [F+2:0]   r_full;
	logic [F:0]     q3;
	logic           vld_s3, asgn_s3, bsgn_s3, dir_s3, last_s3;
	logic [F:0]     amag_s3, bmag_s3, r_s3;
	logic [2*F:0]   v_s3;
	logic [2:0]     smp_s3;

	always_comb begin
		sum3   = (2*F+3)'(aa_s2) + (2*F+3)'(bb_s2);
		r_full = sum3[2*F+2:F];
		q3     = ONE - r_full[F:0];
	end

	// -------------------------------------------------- square root
	logic           v_sq;
	logic [F:0]     root;
	logic [SWS-1:0] side_sq;
	logic [F:0]     sq_amag, sq_bmag, sq_r;
	logic           sq_asgn, sq_bsgn, sq_dir, sq_last;
	logic [2:0]     sq_smp;

	stc_sqrt_pipe #(.RW(QW), .SW(SWS)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (vld_s3),
		.v      (v_s3),
		.side_i ({amag_s3, asgn_s3, bmag_s3, bsgn_s3, r_s3, dir_s3, smp_s3, last_s3}),
		.out_vld(v_sq),
		.root   (root),
		.side_o (side_sq)
	);

	assign {sq_amag, sq_asgn, sq_bmag, sq_bsgn, sq_r, sq_dir, sq_smp, sq_last} = side_sq;

	// -------------------------------------------------- stage 4: direction products
	logic [2*F+1:0] pa4, pb4;
	logic           vld_s4, asgn_s4, bsgn_s4, dir_s4, last_s4;
	logic [F+1:0]   pax_s4, pbx_s4;
	logic [F:0]     r_s4;
	logic [2:0]     smp_s4;

	assign pa4 = (2*F+2)'(root) * (2*F+2)'(sq_amag);
	assign pb4 = (2*F+2)'(root) * (2*F+2)'(sq_bmag);

	// -------------------------------------------------- stage 5: face select
	logic [F+1:0] ax, ay, az, tz, m5;
	logic         xneg, yneg, zneg;
	logic [2:0]   face5;
	logic [F+2:0] ncx, ncy;
	logic         vld_s5, zm_s5, last_s5;
	logic [F+2:0] nx_s5, ny_s5, den_s5;
	logic [2:0]   face_s5, smp_s5;

	// m plus or minus a component no larger than m
	function automatic logic [F+2:0] coord(input logic [F+1:0] m, input logic [F+1:0] mag,
			input logic neg);
		return neg ? ({1'b0, m} - {1'b0, mag}) : ({1'b0, m} + {1'b0, mag});
	endfunction

	always_comb begin
		tz = {r_s4, 1'b0};
		if (dir_s4) begin
			ax   = {pax_s4[F:0], 1'b0};
			ay   = {pbx_s4[F:0], 1'b0};
			xneg = asgn_s4 && (pax_s4 != '0);
			yneg = !bsgn_s4 && (pbx_s4 != '0);
			zneg = tz > (F+2)'(ONE);
			az   = zneg ? (tz - (F+2)'(ONE)) : ((F+2)'(ONE) - tz);
		end else begin
			// outside the disc: straight down -Z
			ax   = '0;
			ay   = '0;
			xneg = 1'b0;
			yneg = 1'b0;
			zneg = 1'b1;
			az   = (F+2)'(ONE);
		end

		if (ax >= ay && ax >= az) begin
			m5    = ax;
			face5 = xneg ? CUBE_NX : CUBE_PX;
			ncx   = coord(ax, az, xneg ? zneg : !zneg);
			ncy   = coord(ax, ay, !yneg);
		end else if (ay >= az) begin
			m5    = ay;
			face5 = yneg ? CUBE_NY : CUBE_PY;
			ncx   = coord(ay, ax, xneg);
			ncy   = coord(ay, az, yneg ? !zneg : zneg);
		end else begin
			m5    = az;
			face5 = zneg ? CUBE_NZ : CUBE_PZ;
			ncx   = coord(az, ax, zneg ? !xneg : xneg);
			ncy   = coord(az, ay, !yneg);
		end
	end

	// -------------------------------------------------- face coordinate divide
	logic           v_d2;
	logic [QW-1:0]  cx_d2, cy_d2;
	logic [SW2-1:0] side_d2;
	logic [2:0]     d2_face, d2_smp;
	logic           d2_zm, d2_last;

	stc_div_pipe #(.DW(DW2), .QW(QW), .SW(SW2)) u_div_face (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (vld_s5),
		.num_x  ({1'b0, nx_s5}),
		.num_y  ({1'b0, ny_s5}),
		.den    (den_s5),
		.side_i ({face_s5, zm_s5, smp_s5, last_s5}),
		.out_vld(v_d2),
		.quo_x  (cx_d2),
		.quo_y  (cy_d2),
		.side_o (side_d2)
	);

	assign {d2_face, d2_zm, d2_smp, d2_last} = side_d2;

	// -------------------------------------------------- stage 6: scale to texels
	logic [PW-1:0] px6, py6;
	logic          vld_s6, last_s6;
	logic [WW:0]   tx_s6, ty_s6;
	logic [2:0]    face_s6, smp_s6;

	assign px6 = PW'(cx_d2) * PW'(w);
	assign py6 = PW'(cy_d2) * PW'(h);

	// -------------------------------------------------- output: clamp
	logic [WW-1:0]    wm1, hm1, clx, cly;
	logic [WW+11:0]   extx, exty;
	logic             out_vld_q, last_q;
	logic [2:0]       face_q, smp_q;
	logic [11:0]      texel_x_q, texel_y_q;

	always_comb begin
		wm1  = w - WW'(1);
		hm1  = h - WW'(1);
		clx  = (tx_s6 > {1'b0, wm1}) ? wm1 : tx_s6[WW-1:0];
		cly  = (ty_s6 > {1'b0, hm1}) ? hm1 : ty_s6[WW-1:0];
		extx = {12'b0, clx};
		exty = {12'b0, cly};
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= v_d1;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= v_sq;
			vld_s5    <= vld_s4;
			vld_s6    <= v_d2;
			out_vld_q <= vld_s6;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			amag_s1 <= amx[F:0];
			bmag_s1 <= amy[F:0];
			asgn_s1 <= a2x[F+2];
			bsgn_s1 <= a2y[F+2];
			inr_s1  <= inr;
			smp_s1  <= side_d1[3:1];
			last_s1 <= side_d1[0];

			aa_s2   <= (2*F+2)'(amag_s1) * (2*F+2)'(amag_s1);
			bb_s2   <= (2*F+2)'(bmag_s1) * (2*F+2)'(bmag_s1);
			amag_s2 <= amag_s1;
			bmag_s2 <= bmag_s1;
			asgn_s2 <= asgn_s1;
			bsgn_s2 <= bsgn_s1;
			inr_s2  <= inr_s1;
			smp_s2  <= smp_s1;
			last_s2 <= last_s1;

			v_s3    <= {q3, {F{1'b0}}};
			r_s3    <= r_full[F:0];
			dir_s3  <= inr_s2 && (r_full <= (F+3)'(ONE));
			amag_s3 <= amag_s2;
			bmag_s3 <= bmag_s2;
			asgn_s3 <= asgn_s2;
			bsgn_s3 <= bsgn_s2;
			smp_s3  <= smp_s2;
			last_s3 <= last_s2;

			pax_s4  <= pa4[2*F+1:F];
			pbx_s4  <= pb4[2*F+1:F];
			asgn_s4 <= sq_asgn;
			bsgn_s4 <= sq_bsgn;
			r_s4    <= sq_r;
			dir_s4  <= sq_dir;
			smp_s4  <= sq_smp;
			last_s4 <= sq_last;

			nx_s5   <= ncx;
			ny_s5   <= ncy;
			den_s5  <= {m5, 1'b0};
			zm_s5   <= (m5 == '0);
			face_s5 <= face5;
			smp_s5  <= smp_s4;
			last_s5 <= last_s4;

			tx_s6   <= d2_zm ? '0 : px6[PW-1:F];
			ty_s6   <= d2_zm ? '0 : py6[PW-1:F];
			face_s6 <= d2_face;
			smp_s6  <= d2_smp;
			last_s6 <= d2_last;

			face_q    <= face_s6;
			texel_x_q <= extx[11:0];
			texel_y_q <= exty[11:0];
			smp_q     <= smp_s6;
			last_q    <= last_s6;
		end
	end

	assign out_valid     = out_vld_q;
	assign face          = face_q;
	assign texel_x       = texel_x_q;
	assign texel_y       = texel_y_q;
	assign sample_number = smp_q;
	assign last          = last_q;

endmodule

// ===== hdl/spheremap_to_cube_texel.sv =====
// ----------------------------------------------------------------------------
// spheremap_to_cube_texel
// Maps sphere map output pixels to cube face texel addresses.
// ----------------------------------------------------------------------------
// Each accepted pixel yields one result (aa_five = 0) or five (aa_five = 1),
// one result per cycle while the output is not stalled, as issued by the
// sample sequencer in the front end. A new pixel is taken in the cycle its
// predecessor issues its last sample. The first result of a pixel passes
// the front end and queue hop, then the two pipelined dividers and the
// pipelined square root, each of which resolves one bit per stage. The
// whole sample pipeline holds while out_stall is high and out_valid is
// set; a 4-entry queue lets the front end keep taking pixels meanwhile.
// Configuration writes are always ready and should be issued while idle.
// ----------------------------------------------------------------------------
module spheremap_to_cube_texel
	import stc_pkg::*;
#(
	parameter int MAX_OUTPUT_SIZE = 4096,
	parameter int MAX_FACE_SIZE   = 4096,
	parameter int FRAC_BITS       = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	// pixel input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	// texel output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  face,
	output logic [11:0] texel_x,
	output logic [11:0] texel_y,
	output logic [2:0]  sample_number,
	output logic        last
);

	localparam int NW    = $clog2(MAX_OUTPUT_SIZE + 1);
	localparam int WW    = $clog2(MAX_FACE_SIZE + 1);
	localparam int RST_N = (1024 > MAX_OUTPUT_SIZE) ? MAX_OUTPUT_SIZE : 1024;
	localparam int RST_W = (1024 > MAX_FACE_SIZE) ? MAX_FACE_SIZE : 1024;
	localparam int QUEUE_DEPTH = 4;

	logic [NW-1:0] n_q;
	logic [WW-1:0] w_q, h_q;
	logic          aa_five_q;
	logic [NW-1:0] n_next;
	logic [WW-1:0] f_next;
	logic          cfg_wr;

	// Size limits applied on write: zero becomes one, large values saturate
	always_comb begin
		if (cfg_data == '0) n_next = NW'(1);
		else if (32'(cfg_data) > MAX_OUTPUT_SIZE) n_next = NW'(MAX_OUTPUT_SIZE);
		else n_next = NW'(cfg_data);

		if (cfg_data == '0) f_next = WW'(1);
		else if (32'(cfg_data) > MAX_FACE_SIZE) f_next = WW'(MAX_FACE_SIZE);
		else f_next = WW'(cfg_data);
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= NW'(RST_N);
			w_q       <= WW'(RST_W);
			h_q       <= WW'(RST_W);
			aa_five_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_OUTPUT_SIZE: n_q       <= n_next;
				CFG_FACE_WIDTH:  w_q       <= f_next;
				CFG_FACE_HEIGHT: h_q       <= f_next;
				CFG_AA_FIVE:     aa_five_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front end and queue
	stc_sample_t fr_data, q_rd;
	logic        q_full, q_push, q_empty, q_pop;
	logic [$bits(stc_sample_t)-1:0] q_rd_vec;

	stc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.aa_five (aa_five_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (fr_data)
	);

	stc_fifo #(.W($bits(stc_sample_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(fr_data),
		.full   (q_full),
		.pop    (q_pop),
		.rd_data(q_rd_vec),
		.empty  (q_empty)
	);

	assign q_rd = q_rd_vec;

	// Back end
	stc_back #(.F(FRAC_BITS), .NW(NW), .WW(WW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.n            (n_q),
		.w            (w_q),
		.h            (h_q),
		.smp_valid    (!q_empty),
		.smp_in       (q_rd),
		.smp_pop      (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.face         (face),
		.texel_x      (texel_x),
		.texel_y      (texel_y),
		.sample_number(sample_number),
		.last         (last)
	);

endmodule

// ===== tb/sv/spheremap_to_cube_texel_test.sv =====
// ----------------------------------------------------------------------------
// spheremap_to_cube_texel_test
// Self-checking bench for the sphere map to cube texel address block.
// ----------------------------------------------------------------------------
// Pixels come from a queue that the stimulus block fills, phase by phase,
// under several register settings. Each accepted pixel is run through a
// fixed-point model of the inverse sphere mapping and face selection. The
// resulting texel transactions are queued and checked in order, field by
// field, against what the block emits. Both sides idle at random, the
// receiver holds off once for a long stretch, and the sender drains once.
// ----------------------------------------------------------------------------
module spheremap_to_cube_texel_test;
	import stc_pkg::*;

	localparam int  FB        = 20;
	localparam int  MAX_SIZE  = 4096;
	localparam int  WDOG_MAX  = 6000;
	localparam int  HOLD_LEN  = 400;
	localparam int  SETTLE    = 150;

	typedef struct {
		logic [11:0] px;
		logic [11:0] py;
	} pixel_t;

	typedef struct {
		logic [2:0]  face;
		logic [11:0] tx;
		logic [11:0] ty;
		logic [2:0]  smp;
		logic        last;
	} texel_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  face;
	logic [11:0] texel_x;
	logic [11:0] texel_y;
	logic [2:0]  sample_number;
	logic        last;

	pixel_t pixel_queue[$];
	texel_t texel_expect[$];

	// shadow copy of the registers
	logic [12:0] sh_out_size;
	logic [12:0] sh_face_w;
	logic [12:0] sh_face_h;
	logic        sh_aa_five;

	int     errors;
	int     cycle_cnt;
	int     idle_cnt;
	int     pixels_in;
	int     texels_out;
	int     hold_req;
	int     hold_seen;
	int     hold_left;

	spheremap_to_cube_texel u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.face(face), .texel_x(texel_x), .texel_y(texel_y),
		.sample_number(sample_number), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic longint unsigned size_limit(input logic [12:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIZE)
			return MAX_SIZE;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// sq * v >> FB, truncated toward zero
	function automatic longint scale_trunc(input longint sq, input longint v);
		longint unsigned mag;
		longint p;
		mag = (v < 0) ? -v : v;
		p = longint'((longint'(sq) * mag) >> FB);
		return (v < 0) ? -p : p;
	endfunction

	function automatic logic [11:0] texel_index(input longint c, input longint m,
			input longint unsigned sz);
		longint unsigned q;
		longint unsigned t;
		if (m <= 0)
			return 12'd0;
		q = (longint'(c + m) << FB) / (longint'(m) * 2);
		t = (q * sz) >> FB;
		if (t > sz - 1)
			t = sz - 1;
		return t[11:0];
	endfunction

	function automatic longint map_coord(input logic [11:0] p, input int d,
			input longint unsigned n);
		longint unsigned num;
		num = 16 * longint'(p) + 8 + d;
		return longint'((num << FB) / (16 * n));
	endfunction

	// expected texel transactions for one pixel under the current registers
	task automatic predict_texels(input pixel_t pix);
		longint one;
		longint unsigned n, w, h;
		int cnt, dx, dy;
		longint s, t, a, b, r, q, sq;
		longint vx, vy, vz, ax, ay, az, sc, tc, m;
		texel_t e;
		one = 64'sd1 << FB;
		n = size_limit(sh_out_size);
		w = size_limit(sh_face_w);
		h = size_limit(sh_face_h);
		cnt = sh_aa_five ? 5 : 1;
		for (int k = 0; k < cnt; k++) begin
			dx = int'(pat_dx(3'(k)));
			dy = int'(pat_dy(3'(k)));
			s = map_coord(pix.px, dx, n);
			t = map_coord(pix.py, dy, n);
			a = 2 * s - one;
			b = 2 * t - one;
			vx = 0;
			vy = 0;
			vz = -one;
			if (a >= -one && a <= one && b >= -one && b <= one) begin
				r = (a * a + b * b) >>> FB;
				q = one - r;
				if (q >= 0) begin
					sq = int_sqrt(q << FB);
					vx = 2 * scale_trunc(sq, a);
					vy = -2 * scale_trunc(sq, b);
					vz = one - 2 * r;
				end
			end
			ax = (vx < 0) ? -vx : vx;
			ay = (vy < 0) ? -vy : vy;
			az = (vz < 0) ? -vz : vz;
			if (ax >= ay && ax >= az)
				e.face = (vx < 0) ? CUBE_NX : CUBE_PX;
			else if (ay >= az)
				e.face = (vy < 0) ? CUBE_NY : CUBE_PY;
			else
				e.face = (vz < 0) ? CUBE_NZ : CUBE_PZ;
			case (e.face)
				CUBE_PX: begin sc = -vz; tc = -vy; m = ax; end
				CUBE_NX: begin sc = vz;  tc = -vy; m = ax; end
				CUBE_PY: begin sc = vx;  tc = vz;  m = ay; end
				CUBE_NY: begin sc = vx;  tc = -vz; m = ay; end
				CUBE_PZ: begin sc = vx;  tc = -vy; m = az; end
				default: begin sc = -vx; tc = -vy; m = az; end
			endcase
			e.tx = texel_index(sc, m, w);
			e.ty = texel_index(tc, m, h);
			e.smp = 3'(k);
			e.last = (k == cnt - 1);
			texel_expect = {texel_expect, e};
		end
	endtask

	// ------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what,
			got, want);
		errors++;
	endtask

	function automatic bit gap_now();
		// long stretch with no idling at all
		if (cycle_cnt >= 3000 && cycle_cnt < 5000)
			return 1'b0;
		return $urandom_range(0, 99) < 11;
	endfunction

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_x <= '0;
			pixel_y <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_texels('{px: pixel_x, py: pixel_y});
				pixels_in++;
			end
			if (!in_valid || !in_stall) begin
				if (pixel_queue.size() != 0 && !gap_now()) begin
					pixel_t p;
					p = pixel_queue.pop_front();
					in_valid <= 1'b1;
					pixel_x <= p.px;
					pixel_y <= p.py;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// texel monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				texels_out++;
				if (texel_expect.size() == 0) begin
					$display("unexpected texel transaction at cycle %0d", cycle_cnt);
					errors++;
				end else begin
					texel_t e;
					e = texel_expect.pop_front();
					if (face !== e.face)
						report_mismatch("face", face, e.face);
					if (texel_x !== e.tx)
						report_mismatch("texel_x", texel_x, e.tx);
					if (texel_y !== e.ty)
						report_mismatch("texel_y", texel_y, e.ty);
					if (sample_number !== e.smp)
						report_mismatch("sample_number", sample_number, e.smp);
					if (last !== e.last)
						report_mismatch("last", last, e.last);
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_LEN;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= gap_now();
			end
		end
	end

	// watchdog: cycles without any accepted transaction
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_MAX) begin
			$display("watchdog expired at cycle %0d", cycle_cnt);
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------- stimulus

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_OUTPUT_SIZE: sh_out_size = val;
			CFG_FACE_WIDTH:  sh_face_w = val;
			CFG_FACE_HEIGHT: sh_face_h = val;
			default:         sh_aa_five = val[0];
		endcase
	endtask

	task automatic set_regs(input logic [12:0] n, input logic [12:0] w,
			input logic [12:0] h, input logic aa);
		write_reg(CFG_OUTPUT_SIZE, n);
		write_reg(CFG_FACE_WIDTH, w);
		write_reg(CFG_FACE_HEIGHT, h);
		write_reg(CFG_AA_FIVE, {12'd0, aa});
	endtask

	// wait until every pixel went in and every texel came out, then settle
	task automatic drain();
		while (pixel_queue.size() != 0 || in_valid || texel_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_pixel(input int x, input int y);
		pixel_t p;
		p.px = 12'(x);
		p.py = 12'(y);
		pixel_queue = {pixel_queue, p};
	endtask

	// mostly inside the map, some anywhere in the 12-bit range
	task automatic add_random(input int cnt);
		int lim;
		lim = int'(size_limit(sh_out_size));
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(0, 9) < 8)
				add_pixel($urandom_range(0, lim - 1), $urandom_range(0, lim - 1));
			else
				add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
		end
	endtask

	initial begin
		int half;
		errors = 0;
		cycle_cnt = 0;
		idle_cnt = 0;
		pixels_in = 0;
		texels_out = 0;
		hold_req = 0;
		sh_out_size = 13'd1024;
		sh_face_w = 13'd1024;
		sh_face_h = 13'd1024;
		sh_aa_five = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset settings, corners, centre, axes, far outside the disc
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(511, 511);
		add_pixel(512, 512);
		add_pixel(1023, 512);
		add_pixel(0, 512);
		add_pixel(512, 0);
		add_pixel(512, 1023);
		add_pixel(150, 150);
		add_pixel(4095, 0);
		drain();

		// directed: five samples, small map, sample edges of the disc
		set_regs(13'd16, 13'd1, 13'd4096, 1'b1);
		add_pixel(0, 8);
		add_pixel(15, 8);
		add_pixel(8, 0);
		add_pixel(7, 7);
		add_pixel(8, 8);
		add_pixel(2, 2);
		drain();

		// directed: zero and oversized registers, one-pixel map
		set_regs(13'd0, 13'd0, 13'd8191, 1'b1);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		drain();
		set_regs(13'd8191, 13'd4096, 13'd1, 1'b0);
		add_pixel(2048, 2048);
		add_pixel(4095, 2047);
		add_pixel(1000, 3000);
		drain();

		// random phases under varied settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(13'd4096, 13'd4096, 13'd4096, 1'b1);
				1: set_regs(13'd2, 13'd3, 13'd2, 1'b0);
				default: set_regs(13'($urandom_range(1, 8191)),
					13'($urandom_range(1, 5000)), 13'($urandom_range(1, 5000)),
					1'($urandom_range(0, 1)));
			endcase
			half = 25;
			add_random(half);
			if (ph == 0) begin
				// long receiver hold-off while pixels keep coming
				hold_req = hold_req + 1;
			end
			if (ph == 2) begin
				// sender pause until all texels are back
				while (pixel_queue.size() != 0 || in_valid || texel_expect.size() != 0)
					@(posedge clk);
			end
			add_random(half);
			drain();
		end

		$display("covered %0d pixels and %0d texel transactions over 10 register settings",
			pixels_in, texels_out);
		$display("including zero, oversized and one-texel sizes, both sample modes");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
